// ===== rtl/core/hwcg_pkg.sv =====
// ----------------------------------------------------------------------------
// hwcg_pkg
// Shared types and constants of the Hann window coefficient generator.
// ----------------------------------------------------------------------------
package hwcg_pkg;

   localparam int          NUM_STEPS        = 5;
   localparam int          DIV_CELLS        = 31;
   localparam logic [31:0] PI_Q30           = 32'd3373259426;
   localparam logic [30:0] ONE_Q30          = 31'h4000_0000;
   localparam logic [0:0]  CSR_WINDOW_LENGTH = 1'b0;
   localparam logic [0:0]  CSR_PERIODIC_MODE = 1'b1;
   localparam logic [12:0] WINDOW_LENGTH_RESET = 13'd512;

   localparam logic [6:0]  STEP_K [NUM_STEPS] = '{7'd110, 7'd72, 7'd42, 7'd20, 7'd6};
   localparam logic [29:0] STEP_RECIP [NUM_STEPS] =
      '{30'd39045157, 30'd59652323, 30'd102261126, 30'd214748364, 30'd715827882};

   typedef struct packed {
      logic        valid;
      logic        oor;
      logic [13:0] rem;
      logic [30:0] bits;
      logic [30:0] quo;
   } div_type;

   typedef struct packed {
      logic        valid;
      logic        oor;
      logic [30:0] t;
      logic [31:0] t2;
      logic [30:0] h;
   } poly_type;

endpackage

// ===== rtl/core/hwcg_div_cell.sv =====
// ----------------------------------------------------------------------------
// hwcg_div_cell
// One restoring division cell: produces one quotient bit per request.
// ----------------------------------------------------------------------------
module hwcg_div_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic [13:0]       den,
   input  hwcg_pkg::div_type upstream,
   output hwcg_pkg::div_type downstream
);

   hwcg_pkg::div_type stage_ff;
   hwcg_pkg::div_type stage_in;
   logic [14:0]       trial;
   logic [14:0]       diff;
   logic              ge;

   always_comb begin
      trial          = {upstream.rem, upstream.bits[30]};
      diff           = trial - {1'b0, den};
      ge             = (trial >= {1'b0, den});
      stage_in.valid = upstream.valid;
      stage_in.oor   = upstream.oor;
      stage_in.rem   = ge ? diff[13:0] : trial[13:0];
      stage_in.bits  = {upstream.bits[29:0], 1'b0};
      stage_in.quo   = {upstream.quo[29:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (advance) begin
         stage_ff.valid <= stage_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         stage_ff.oor  <= stage_in.oor;
         stage_ff.rem  <= stage_in.rem;
         stage_ff.bits <= stage_in.bits;
         stage_ff.quo  <= stage_in.quo;
      end
   end

   assign downstream = stage_ff;

endmodule

// ===== rtl/core/hwcg_horner_step.sv =====
// ----------------------------------------------------------------------------
// hwcg_horner_step
// One nested sine series step: h = 1 - floor(((t2*h) >> 30) / k), three stages.
// ----------------------------------------------------------------------------
module hwcg_horner_step (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic [6:0]         k,
   input  logic [29:0]        recip,
   input  hwcg_pkg::poly_type upstream,
   output hwcg_pkg::poly_type downstream
);

   hwcg_pkg::poly_type s1_ff, s2_ff, s3_ff;
   hwcg_pkg::poly_type s3_in;
   logic [31:0]        p1_ff, p1_in;
   logic [31:0]        p2_ff;
   logic [29:0]        q2_ff, q2_in;
   logic [61:0]        prod_h;
   logic [61:0]        prod_r;
   logic [32:0]        rem;
   logic [30:0]        q;

   always_comb begin
      prod_h = 62'(upstream.t2) * 62'(upstream.h);
      p1_in  = prod_h[61:30];
      prod_r = 62'(p1_ff) * 62'(recip);
      q2_in  = prod_r[61:32];
      rem    = {1'b0, p2_ff} - 33'(37'(q2_ff) * 37'(k));
      q      = 31'(q2_ff) + ((rem >= 33'(k)) ? 31'd1 : 31'd0);
      s3_in   = s2_ff;
      s3_in.h = hwcg_pkg::ONE_Q30 - q;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid <= 1'b0;
         s2_ff.valid <= 1'b0;
         s3_ff.valid <= 1'b0;
      end else if (advance) begin
         s1_ff.valid <= upstream.valid;
         s2_ff.valid <= s1_ff.valid;
         s3_ff.valid <= s2_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ff.oor <= upstream.oor;
         s1_ff.t   <= upstream.t;
         s1_ff.t2  <= upstream.t2;
         s1_ff.h   <= upstream.h;
         p1_ff     <= p1_in;
         s2_ff.oor <= s1_ff.oor;
         s2_ff.t   <= s1_ff.t;
         s2_ff.t2  <= s1_ff.t2;
         s2_ff.h   <= s1_ff.h;
         p2_ff     <= p1_ff;
         q2_ff     <= q2_in;
         s3_ff.oor <= s3_in.oor;
         s3_ff.t   <= s3_in.t;
         s3_ff.t2  <= s3_in.t2;
         s3_ff.h   <= s3_in.h;
      end
   end

   assign downstream = s3_ff;

endmodule

// ===== rtl/core/hann_window_coefficient_generator.sv =====
// ----------------------------------------------------------------------------
// hann_window_coefficient_generator
// Streams one Hann window coefficient per requested sample index.
// ----------------------------------------------------------------------------
// Accepts one request per clock while no response is stalled, and returns
// one response per request, in order; throughput is set by the fully pipelined
// datapath: a chain of 31 division cells (one angle bit each) followed by five
// three-stage sine series steps. The whole pipe holds while a response waits.
// Write window_length and periodic_mode only while no request is in flight.
module hann_window_coefficient_generator #(
   parameter int MAX_LENGTH = 4096,
   parameter int COEFF_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [15:0]                          req_tdata,  // sample_index[11:0]
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [((COEFF_BITS+7)/8)*8-1:0]      rsp_tdata,  // coefficient
   output logic                                 rsp_tuser,  // index_out_of_range
   input  logic                                 csr_we,
   input  logic [0:0]                           csr_index,
   input  logic [12:0]                          csr_data
);

   localparam int TDATA_BITS = ((COEFF_BITS + 7) / 8) * 8;

   logic [12:0] window_length_ff;
   logic        periodic_mode_ff;
   logic        advance;
   logic [12:0] len_eff;
   logic [13:0] den;
   logic [13:0] n;
   logic [13:0] mirror;
   logic [11:0] sample_index;
   logic        oor_in;

   logic        a_valid_ff, a_oor_ff;
   logic [12:0] a_m_ff, a_m_in;
   hwcg_pkg::div_type  div_st [0:hwcg_pkg::DIV_CELLS];
   logic [44:0]        num_in;
   hwcg_pkg::poly_type poly_st [0:hwcg_pkg::NUM_STEPS];
   logic [61:0]        tt;
   logic               t2_valid_ff, t2_oor_ff;
   logic [30:0]        t2_t_ff;
   logic [31:0]        t2_ff;
   logic               s_valid_ff, s_oor_ff, q_valid_ff, q_oor_ff;
   logic [61:0]        th;
   logic [30:0]        s_ff;
   logic [61:0]        sq_ff;
   logic [63:0]        rounded;
   logic [63:0]        scaled;
   logic [COEFF_BITS-1:0] coef_in;
   logic                  rsp_tvalid_ff;
   logic [COEFF_BITS-1:0] coef_ff;
   logic                  oor_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_length_ff <= hwcg_pkg::WINDOW_LENGTH_RESET;
         periodic_mode_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            hwcg_pkg::CSR_WINDOW_LENGTH: window_length_ff <= csr_data;
            hwcg_pkg::CSR_PERIODIC_MODE: periodic_mode_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   assign advance    = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = advance;

   always_comb begin
      sample_index = req_tdata[11:0];
      if (32'(window_length_ff) > MAX_LENGTH) begin
         len_eff = 13'(MAX_LENGTH);
      end else begin
         len_eff = window_length_ff;
      end
      oor_in = ({1'b0, sample_index} >= len_eff);
      if (periodic_mode_ff) begin
         den = {1'b0, len_eff};
         n   = {2'b0, sample_index};
      end else begin
         den = {1'b0, len_eff} + 14'd1;
         n   = {2'b0, sample_index} + 14'd1;
      end
      mirror = den - n;
      a_m_in = (mirror < n) ? mirror[12:0] : n[12:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_oor_ff <= oor_in;
         a_m_ff   <= a_m_in;
      end
   end

   assign num_in = 45'(a_m_ff) * 45'(hwcg_pkg::PI_Q30) + 45'(den[13:1]);

   always_ff @(posedge clock) begin
      if (reset) begin
         div_st[0].valid <= 1'b0;
      end else if (advance) begin
         div_st[0].valid <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         div_st[0].oor  <= a_oor_ff;
         div_st[0].rem  <= num_in[44:31];
         div_st[0].bits <= num_in[30:0];
         div_st[0].quo  <= '0;
      end
   end

   for (genvar i = 0; i < hwcg_pkg::DIV_CELLS; i++) begin : g_div
      hwcg_div_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .advance    (advance),
         .den        (den),
         .upstream   (div_st[i]),
         .downstream (div_st[i+1])
      );
   end

   assign tt = 62'(div_st[hwcg_pkg::DIV_CELLS].quo) * 62'(div_st[hwcg_pkg::DIV_CELLS].quo);

   always_ff @(posedge clock) begin
      if (reset) begin
         t2_valid_ff <= 1'b0;
      end else if (advance) begin
         t2_valid_ff <= div_st[hwcg_pkg::DIV_CELLS].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         t2_oor_ff <= div_st[hwcg_pkg::DIV_CELLS].oor;
         t2_t_ff   <= div_st[hwcg_pkg::DIV_CELLS].quo;
         t2_ff     <= tt[61:30];
      end
   end

   always_comb begin
      poly_st[0].valid = t2_valid_ff;
      poly_st[0].oor   = t2_oor_ff;
      poly_st[0].t     = t2_t_ff;
      poly_st[0].t2    = t2_ff;
      poly_st[0].h     = hwcg_pkg::ONE_Q30;
   end

   for (genvar j = 0; j < hwcg_pkg::NUM_STEPS; j++) begin : g_step
      hwcg_horner_step u_step (
         .clock      (clock),
         .reset      (reset),
         .advance    (advance),
         .k          (hwcg_pkg::STEP_K[j]),
         .recip      (hwcg_pkg::STEP_RECIP[j]),
         .upstream   (poly_st[j]),
         .downstream (poly_st[j+1])
      );
   end

   assign th = 62'(poly_st[hwcg_pkg::NUM_STEPS].t) * 62'(poly_st[hwcg_pkg::NUM_STEPS].h);

   always_ff @(posedge clock) begin
      if (reset) begin
         s_valid_ff <= 1'b0;
         q_valid_ff <= 1'b0;
      end else if (advance) begin
         s_valid_ff <= poly_st[hwcg_pkg::NUM_STEPS].valid;
         q_valid_ff <= s_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s_oor_ff <= poly_st[hwcg_pkg::NUM_STEPS].oor;
         s_ff     <= th[60:30];
         q_oor_ff <= s_oor_ff;
         sq_ff    <= 62'(s_ff) * 62'(s_ff);
      end
   end

   always_comb begin
      rounded = {2'b0, sq_ff} + (64'd1 << (59 - COEFF_BITS));
      scaled  = rounded >> (60 - COEFF_BITS);
      if (q_oor_ff) begin
         coef_in = '0;
      end else if (scaled > ((64'd1 << COEFF_BITS) - 64'd1)) begin
         coef_in = '1;
      end else begin
         coef_in = scaled[COEFF_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (advance) begin
         rsp_tvalid_ff <= q_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         coef_ff <= coef_in;
         oor_ff  <= q_oor_ff;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = TDATA_BITS'(coef_ff);
   assign rsp_tuser  = oor_ff;

endmodule

// ===== rtl/core/hwcg_checker.sv =====
// ----------------------------------------------------------------------------
// hwcg_checker
// Port-level checks of the Hann window coefficient generator.
// ----------------------------------------------------------------------------
module hwcg_checker #(
   parameter int COEFF_BITS = 16
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [((COEFF_BITS+7)/8)*8-1:0] rsp_tdata,
   input logic                            rsp_tuser
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("out-of-range response carries a coefficient");

   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("request taken while response stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request refused with empty output");

endmodule

bind hann_window_coefficient_generator hwcg_checker #(
   .COEFF_BITS (COEFF_BITS)
) u_hwcg_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
